// File: rtl/core/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants for the pressure sensor compensation block.
// ----------------------------------------------------------------------------
package psc_pkg;

  // Input command and result kind codes
  localparam logic CMD_TEMP = 1'b0;
  localparam logic CMD_PRES = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_CAL_A = 2'd0;
  localparam logic [1:0] REG_CAL_B = 2'd1;
  localparam logic [1:0] REG_CAL_C = 2'd2;
  localparam logic [1:0] REG_OSS   = 2'd3;

  localparam logic [1:0] OSS_RESET = 2'd1;

  // Compensation constants
  localparam logic signed [31:0] K_B6_OFS    = 32'sd4000;
  localparam logic signed [31:0] K_Y1_GAIN   = 32'sd3038;
  localparam logic signed [31:0] K_Y2_GAIN   = -32'sd7357;
  localparam logic signed [31:0] K_P_OFS     = 32'sd3791;
  localparam logic [31:0]        K_P_SCALE   = 32'd50000;
  localparam logic signed [31:0] K_B4_OFS    = 32'sd32768;
  localparam logic signed [31:0] K_DEG_MAX   = 32'sd127;
  localparam logic signed [31:0] K_DEG_MIN   = -32'sd128;
  localparam logic signed [31:0] K_HPA_MAX   = 32'sd4095;

  // Reciprocals for unsigned 32-bit division by 10 (product >> 35)
  // and by 100 (product >> 37)
  localparam logic [31:0]        K_RCP10     = 32'hCCCC_CCCD;
  localparam logic [31:0]        K_RCP100    = 32'h51EB_851F;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_T_MUL,
    S_T_X1,
    S_T_DIV,
    S_T_RND,
    S_T_S10,
    S_T_W10,
    S_P_SQ,
    S_P_A,
    S_P_B,
    S_P_C,
    S_P_D,
    S_P_E,
    S_P_F0,
    S_P_F,
    S_P_G,
    S_P_H,
    S_P_DIV,
    S_P_Y,
    S_P_Y1,
    S_P_Y2,
    S_P_Y3,
    S_P_Y4,
    S_P_S100,
    S_P_W100,
    S_DONE
  } state_e;

  // Divider request and response
  typedef struct packed {
    logic        start;
    logic        sgn;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

endpackage

// File: rtl/core/psc_mul.sv
// ----------------------------------------------------------------------------
// psc_mul
// Shared 32x32 multiplier, full unsigned product in two halves, registered.
// ----------------------------------------------------------------------------
module psc_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o,
  output logic [31:0] p_hi_o
);

  logic [63:0] p_d;
  logic [63:0] p_q;

  // low half wraps the same for signed and unsigned operands
  assign p_d = {32'b0, a_i} * {32'b0, b_i};

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o    = p_q[31:0];
  assign p_hi_o = p_q[63:32];

endmodule

// File: rtl/core/psc_div.sv
// ----------------------------------------------------------------------------
// psc_div
// Shared bit-serial 32-bit divider, signed or unsigned, truncating quotient.
// ----------------------------------------------------------------------------
module psc_div
  import psc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        run_q, run_d;
  logic        fix_q, fix_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [31:0] res_q, res_d;

  logic [31:0] num_abs;
  logic [31:0] den_abs;
  logic [32:0] trial;

  // magnitudes of the operands for a signed request
  assign num_abs = (req_i.sgn && req_i.num[31]) ? (~req_i.num + 32'd1) : req_i.num;
  assign den_abs = (req_i.sgn && req_i.den[31]) ? (~req_i.den + 32'd1) : req_i.den;
  assign trial   = {rem_q, quo_q[31]} - {1'b0, den_q};

  // one quotient bit per cycle, then a sign fix step
  always_comb begin
    run_d  = run_q;
    fix_d  = 1'b0;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    res_d  = res_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = num_abs;
      den_d = den_abs;
      neg_d = req_i.sgn & (req_i.num[31] ^ req_i.den[31]);
    end else if (run_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == '1) begin
        run_d = 1'b0;
        fix_d = 1'b1;
      end
    end else if (fix_q) begin
      res_d  = neg_q ? (~quo_q + 32'd1) : quo_q;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      fix_q  <= fix_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = res_q;

endmodule

// File: rtl/core/pressure_sensor_compensation.sv
// ----------------------------------------------------------------------------
// pressure_sensor_compensation
// Integer compensation of raw barometric sensor temperature and pressure.
// ----------------------------------------------------------------------------
// Slave stream: tuser = command (0 temperature, 1 pressure), tdata = raw
//   reading; s_axis_tready is high only while the sequencer is idle.
// Master stream: one result per request, tuser = {divide_fault,
//   result_kind}, tdata = {pressure_hpa, temperature_deg}.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 cal word A, 1 cal word B, 2 cal word C, 3 oversampling); the user must
//   write only while idle, and the block itself does not enforce it.
// Sequence: each request steps through the sequencer states: the shared
//   bit-serial divider once, otherwise single steps on the shared multiplier
//   and working registers. A zero divisor skips the divider and sets divide_fault.
// Requests: one at a time; the next is taken in the idle state after the handoff.
// Reset: calibration words and the stored B5 clear, oversampling goes to 1,
//   the sequencer returns to idle and the output register empties.
// Stall: a result waits in the output register while the next request runs;
//   that one holds in the sequencer until the register frees up.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation
  import psc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] raw_reading
  input  logic        s_axis_tuser,   // [0] command
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] temperature_deg, [19:8] pressure_hpa, zero pad
  output logic [1:0]  m_axis_tuser    // [0] result_kind, [1] divide_fault
);

  // configuration
  logic [63:0] cal_a_q;
  logic [63:0] cal_b_q;
  logic [31:0] cal_c_q;
  logic [1:0]  oss_q;

  // sequencer and working registers
  state_e             state_q, state_d;
  logic signed [31:0] b5_q, b5_d;
  logic signed [31:0] w0_q, w0_d;
  logic signed [31:0] w1_q, w1_d;
  logic signed [31:0] w2_q, w2_d;
  logic signed [31:0] w3_q, w3_d;
  logic               big_q, big_d;
  logic               cmd_q, cmd_d;
  logic [23:0]        raw_q, raw_d;
  logic [7:0]         rdeg_q, rdeg_d;
  logic [11:0]        rhpa_q, rhpa_d;
  logic               rflt_q, rflt_d;

  // output register
  logic               out_vld_q, out_vld_d;
  logic [23:0]        out_data_q, out_data_d;
  logic [1:0]         out_user_q, out_user_d;

  // shared units
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_p;
  logic [31:0] mul_hi;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // decoded coefficients
  logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [31:0]        ac4, ac5, ac6;
  logic signed [31:0] b6;
  logic signed [31:0] t_x1;
  logic signed [31:0] t_den;
  logic [23:0]        up_raw;
  logic [31:0]        p_scale;
  logic signed [31:0] quo_s;
  logic [31:0]        deg_mag;
  logic signed [31:0] deg_s;
  logic [31:0]        hpa_mag;
  logic signed [31:0] hpa_s;
  logic               in_req;
  logic               out_free;

  // signed divide by 2^k, truncating toward zero
  function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] x,
                                                 input logic [4:0] k);
    logic signed [31:0] bias;
    bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
    return (x + bias) >>> k;
  endfunction

  assign ac1 = {{16{cal_a_q[63]}}, cal_a_q[63:48]};
  assign ac2 = {{16{cal_a_q[47]}}, cal_a_q[47:32]};
  assign ac3 = {{16{cal_a_q[31]}}, cal_a_q[31:16]};
  assign ac4 = {16'b0, cal_a_q[15:0]};
  assign ac5 = {16'b0, cal_b_q[63:48]};
  assign ac6 = {16'b0, cal_b_q[47:32]};
  assign b1  = {{16{cal_b_q[31]}}, cal_b_q[31:16]};
  assign b2  = {{16{cal_b_q[15]}}, cal_b_q[15:0]};
  assign mc  = {{16{cal_c_q[31]}}, cal_c_q[31:16]};
  assign md  = {{16{cal_c_q[15]}}, cal_c_q[15:0]};

  assign b6      = b5_q - K_B6_OFS;
  assign t_x1    = $signed(mul_p) >>> 15;
  assign t_den   = t_x1 + md;
  assign p_scale = K_P_SCALE >> oss_q;
  assign quo_s   = $signed(div_rsp.quo);
  assign in_req  = s_axis_tvalid & s_axis_tready;
  assign out_free = ~out_vld_q | m_axis_tready;

  // truncating quotients by 10 and 100 from the reciprocal products
  assign deg_mag = {3'b0, mul_hi[31:3]};
  assign deg_s   = w1_q[31] ? $signed(~deg_mag + 32'd1) : $signed(deg_mag);
  assign hpa_mag = {5'b0, mul_hi[31:5]};
  assign hpa_s   = w0_q[31] ? $signed(~hpa_mag + 32'd1) : $signed(hpa_mag);

  // uncompensated pressure from the oversampling setting
  always_comb begin
    case (oss_q)
      2'd0:    up_raw = raw_q >> 8;
      2'd1:    up_raw = raw_q >> 7;
      2'd2:    up_raw = raw_q >> 6;
      default: up_raw = raw_q >> 5;
    endcase
  end

  psc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .p_o    (mul_p),
    .p_hi_o (mul_hi)
  );

  psc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_req) begin
                  state_d = (s_axis_tuser == CMD_PRES) ? S_P_SQ : S_T_MUL;
                end
      S_T_MUL:  state_d = S_T_X1;
      S_T_X1:   state_d = (t_den == 32'sd0) ? S_DONE : S_T_DIV;
      S_T_DIV:  if (div_rsp.done) begin
                  state_d = S_T_RND;
                end
      S_T_RND:  state_d = S_T_S10;
      S_T_S10:  state_d = S_T_W10;
      S_T_W10:  state_d = S_DONE;
      S_P_SQ:   state_d = S_P_A;
      S_P_A:    state_d = S_P_B;
      S_P_B:    state_d = S_P_C;
      S_P_C:    state_d = S_P_D;
      S_P_D:    state_d = S_P_E;
      S_P_E:    state_d = S_P_F0;
      S_P_F0:   state_d = S_P_F;
      S_P_F:    state_d = S_P_G;
      S_P_G:    state_d = S_P_H;
      S_P_H:    state_d = (w3_q == 32'sd0) ? S_DONE : S_P_DIV;
      S_P_DIV:  if (div_rsp.done) begin
                  state_d = S_P_Y;
                end
      S_P_Y:    state_d = S_P_Y1;
      S_P_Y1:   state_d = S_P_Y2;
      S_P_Y2:   state_d = S_P_Y3;
      S_P_Y3:   state_d = S_P_Y4;
      S_P_Y4:   state_d = S_P_S100;
      S_P_S100: state_d = S_P_W100;
      S_P_W100: state_d = S_DONE;
      S_DONE:   if (out_free) begin
                  state_d = S_IDLE;
                end
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath control per state
  always_comb begin
    b5_d    = b5_q;
    w0_d    = w0_q;
    w1_d    = w1_q;
    w2_d    = w2_q;
    w3_d    = w3_q;
    big_d   = big_q;
    cmd_d   = cmd_q;
    raw_d   = raw_q;
    rdeg_d  = rdeg_q;
    rhpa_d  = rhpa_q;
    rflt_d  = rflt_q;
    mul_a   = '0;
    mul_b   = '0;
    div_req = '0;

    // output register drains on the receiver's ready
    out_vld_d  = out_vld_q & ~m_axis_tready;
    out_data_d = out_data_q;
    out_user_d = out_user_q;

    case (state_q)
      S_IDLE: begin
        if (in_req) begin
          cmd_d  = s_axis_tuser;
          raw_d  = s_axis_tdata;
          rdeg_d = '0;
          rhpa_d = '0;
          rflt_d = 1'b0;
        end
      end

      // temperature: X1 = (UT - AC6) * AC5 >> 15
      S_T_MUL: begin
        mul_a = {16'b0, raw_q[15:0]} - ac6;
        mul_b = ac5;
      end
      // X2 = MC * 2048 / (X1 + MD)
      S_T_X1: begin
        w0_d = t_x1;
        if (t_den == 32'sd0) begin
          rflt_d = 1'b1;
        end else begin
          div_req.start = 1'b1;
          div_req.sgn   = 1'b1;
          div_req.num   = {mc[20:0], 11'b0};
          div_req.den   = t_den;
        end
      end
      S_T_DIV: begin
        if (div_rsp.done) begin
          b5_d = w0_q + quo_s;
        end
      end
      S_T_RND: w1_d = (b5_q + 32'sd8) >>> 4;
      // divide by 10: reciprocal multiply of the magnitude
      S_T_S10: begin
        mul_a = w1_q[31] ? (~w1_q + 32'd1) : w1_q;
        mul_b = K_RCP10;
      end
      S_T_W10: begin
        if (deg_s > K_DEG_MAX) begin
          rdeg_d = K_DEG_MAX[7:0];
        end else if (deg_s < K_DEG_MIN) begin
          rdeg_d = K_DEG_MIN[7:0];
        end else begin
          rdeg_d = deg_s[7:0];
        end
      end

      // pressure: B6 squared
      S_P_SQ: begin
        mul_a = b6;
        mul_b = b6;
      end
      S_P_A: begin
        w0_d  = $signed(mul_p);
        mul_a = ac2;
        mul_b = b6;
      end
      S_P_B: begin
        w1_d  = sdiv_p2($signed(mul_p), 5'd11);
        mul_a = b2;
        mul_b = sdiv_p2(w0_q, 5'd12);
      end
      // AC1 * 4 + X3
      S_P_C: begin
        w1_d  = sdiv_p2($signed(mul_p), 5'd11) + w1_q + (ac1 <<< 2);
        mul_a = ac3;
        mul_b = b6;
      end
      // B3, and the second X1
      S_P_D: begin
        w3_d  = $signed(mul_p) >>> 13;
        w2_d  = sdiv_p2((w1_q << oss_q) + 32'sd2, 5'd2);
        mul_a = b1;
        mul_b = w0_q >>> 12;
      end
      S_P_E: w3_d = w3_q + ($signed(mul_p) >>> 16) + 32'sd2;
      S_P_F0: begin
        w3_d = (w3_q >>> 2) + K_B4_OFS;
        w2_d = $signed({8'b0, up_raw}) - w2_q;
      end
      // B4 = AC4 * (X3 + 32768) >> 15, unsigned
      S_P_F: begin
        mul_a = ac4;
        mul_b = w3_q;
      end
      // B7 = (UP - B3) * (50000 >> oss)
      S_P_G: begin
        w3_d  = $signed({15'b0, mul_p[31:15]});
        mul_a = w2_q;
        mul_b = p_scale;
      end
      S_P_H: begin
        if (w3_q == 32'sd0) begin
          rflt_d = 1'b1;
        end else begin
          big_d         = mul_p[31];
          div_req.start = 1'b1;
          div_req.num   = mul_p[31] ? mul_p : {mul_p[30:0], 1'b0};
          div_req.den   = w3_q;
        end
      end
      S_P_DIV: begin
        if (div_rsp.done) begin
          w0_d = big_q ? {quo_s[30:0], 1'b0} : quo_s;
        end
      end
      // final correction terms
      S_P_Y: begin
        mul_a = w0_q >>> 8;
        mul_b = w0_q >>> 8;
      end
      S_P_Y1: begin
        mul_a = mul_p;
        mul_b = K_Y1_GAIN;
      end
      S_P_Y2: begin
        w1_d  = $signed(mul_p) >>> 16;
        mul_a = K_Y2_GAIN;
        mul_b = w0_q;
      end
      S_P_Y3: w1_d = w1_q + ($signed(mul_p) >>> 16) + K_P_OFS;
      S_P_Y4: w0_d = w0_q + (w1_q >>> 4);
      // divide by 100: reciprocal multiply of the magnitude
      S_P_S100: begin
        mul_a = w0_q[31] ? (~w0_q + 32'd1) : w0_q;
        mul_b = K_RCP100;
      end
      S_P_W100: begin
        if (hpa_s < 32'sd0) begin
          rhpa_d = '0;
        end else if (hpa_s > K_HPA_MAX) begin
          rhpa_d = K_HPA_MAX[11:0];
        end else begin
          rhpa_d = hpa_s[11:0];
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_data_d = {4'b0, rhpa_q, rdeg_q};
          out_user_d = {rflt_q, cmd_q};
        end
      end

      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_a_q <= '0;
      cal_b_q <= '0;
      cal_c_q <= '0;
      oss_q   <= OSS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CAL_A: cal_a_q <= cfg_wdata_i;
        REG_CAL_B: cal_b_q <= cfg_wdata_i;
        REG_CAL_C: cal_c_q <= cfg_wdata_i[31:0];
        REG_OSS:   oss_q   <= cfg_wdata_i[1:0];
        default:   oss_q   <= oss_q;
      endcase
    end
  end

  // control state and stored B5
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      b5_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      b5_q      <= b5_d;
      out_vld_q <= out_vld_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    w0_q       <= w0_d;
    w1_q       <= w1_d;
    w2_q       <= w2_d;
    w3_q       <= w3_d;
    big_q      <= big_d;
    cmd_q      <= cmd_d;
    raw_q      <= raw_d;
    rdeg_q     <= rdeg_d;
    rhpa_q     <= rhpa_d;
    rflt_q     <= rflt_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
